>>> sv/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Types, constants and helper functions for the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

  localparam int HUE_W  = 9;
  localparam int UNIT_W = 13;
  localparam int CHAN_W = 8;
  localparam int K_W    = 6;

  localparam logic [HUE_W-1:0]  DEG_WRAP   = HUE_W'(360);
  localparam logic [HUE_W:0]    DEG_WRAP_X = (HUE_W+1)'(360);
  localparam logic [HUE_W-1:0]  SEG_DEG    = HUE_W'(60);
  localparam logic [HUE_W-1:0]  DEG_FLAT   = HUE_W'(180);
  localparam logic [HUE_W-1:0]  DEG_FALL   = HUE_W'(240);
  localparam logic [HUE_W:0]    DEG_THIRD  = (HUE_W+1)'(120);
  localparam logic [HUE_W:0]    DEG_2THIRD = (HUE_W+1)'(240);
  localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(255);

  typedef struct packed {
    logic [HUE_W-1:0]  hue_degrees;
    logic [UNIT_W-1:0] saturation;
    logic [UNIT_W-1:0] lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } hsl_out_t;

  // Folds an angle of 0..599 back into 0..359.
  function automatic logic [HUE_W-1:0] wrap_deg(input logic [HUE_W:0] t);
    logic [HUE_W:0] r;
    r = (t >= DEG_WRAP_X) ? (t - DEG_WRAP_X) : t;
    return r[HUE_W-1:0];
  endfunction

  // Weight of (m2 - m1) in the ramp, in sixtieths: value*60 = m1*60 + d*k.
  function automatic logic [K_W-1:0] ramp_k(input logic [HUE_W-1:0] t);
    logic [HUE_W-1:0] r;
    if (t < SEG_DEG) begin
      r = t;
    end else if (t < DEG_FLAT) begin
      r = SEG_DEG;
    end else if (t < DEG_FALL) begin
      r = DEG_FALL - t;
    end else begin
      r = '0;
    end
    return r[K_W-1:0];
  endfunction

endpackage

>>> sv/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Four-stage pipeline that turns an HSL color into 8-bit RGB, exactly.
// ----------------------------------------------------------------------------
//
//  channel | direction | word       | handshake
//  --------+-----------+------------+-----------------------
//  in_     | input     | hsl_in_t   | in_valid / in_stall
//  out_    | output    | hsl_out_t  | out_valid / out_stall
//
//  One word enters per cycle while in_stall is low; each result passes through
//  the stages in order (lightness times saturation product, m1/m2, ramp multiply,
//  scale by 255/60) and is taken when the output is not stalled.
//  Reset clears only the stage valid bits; the pipeline is empty after reset.
//  Each stage holds while the next one is full and blocked, so bubbles close
//  up under a stall and the input keeps moving until the pipe is full.
//
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsl_pkg::hsl_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hsl_pkg::hsl_out_t  out_data
);
  import hsl_pkg::*;

  localparam int CW     = FRAC_BITS + 1;
  localparam int WIDE_W = (UNIT_W > CW) ? UNIT_W : CW;
  localparam int MX_W   = 2 * FRAC_BITS + 2;
  localparam int M_W    = 2 * FRAC_BITS + 1;
  localparam int NUM_W  = 2 * FRAC_BITS + 6;
  localparam int PRD_W  = NUM_W + 5;
  localparam int SHR    = 2 * FRAC_BITS + 2;

  localparam logic [WIDE_W-1:0] ONE_WIDE = WIDE_W'(1) << FRAC_BITS;
  localparam logic [CW-1:0]     ONE_Q    = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]     HALF_Q   = CW'(1) << (FRAC_BITS - 1);

  // Per-stage ready: a stage loads when it is empty or its successor loads.
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign out_valid = v4_r;

  // Stage 1: clamp, hue weights, lightness times saturation.
  logic [WIDE_W-1:0] s_ext, l_ext;
  logic [CW-1:0]     s_cl, l_cl;
  logic [HUE_W-1:0]  hue_w;
  logic [K_W-1:0]    kr_nxt, kg_nxt, kb_nxt;
  logic [K_W-1:0]    kr1_r, kg1_r, kb1_r;
  logic [CW-1:0]     s1_r, l1_r;
  logic [MX_W-1:0]   ls1_r;

  always_comb begin
    s_ext  = WIDE_W'(in_data.saturation);
    l_ext  = WIDE_W'(in_data.lightness);
    s_cl   = (s_ext > ONE_WIDE) ? ONE_Q : s_ext[CW-1:0];
    l_cl   = (l_ext > ONE_WIDE) ? ONE_Q : l_ext[CW-1:0];
    hue_w  = wrap_deg({1'b0, in_data.hue_degrees});
    kr_nxt = ramp_k(wrap_deg({1'b0, hue_w} + DEG_THIRD));
    kg_nxt = ramp_k(hue_w);
    kb_nxt = ramp_k(wrap_deg({1'b0, hue_w} + DEG_2THIRD));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      kr1_r <= kr_nxt;
      kg1_r <= kg_nxt;
      kb1_r <= kb_nxt;
      s1_r  <= s_cl;
      l1_r  <= l_cl;
      ls1_r <= MX_W'(l_cl) * MX_W'(s_cl);
    end
  end

  // Stage 2: m2, m1 and their difference, all over ONE squared.
  logic [MX_W-1:0] l_x, s_x, m2_x, m1_x, d_x;
  logic [M_W-1:0]  m1_2_r, d2_r;
  logic [K_W-1:0]  kr2_r, kg2_r, kb2_r;

  always_comb begin
    l_x = MX_W'(l1_r) << FRAC_BITS;
    s_x = MX_W'(s1_r) << FRAC_BITS;
    if (l1_r <= HALF_Q) begin
      m2_x = l_x + ls1_r;
    end else begin
      m2_x = l_x + s_x - ls1_r;
    end
    m1_x = (l_x << 1) - m2_x;
    d_x  = m2_x - m1_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      m1_2_r <= m1_x[M_W-1:0];
      d2_r   <= d_x[M_W-1:0];
      kr2_r  <= kr1_r;
      kg2_r  <= kg1_r;
      kb2_r  <= kb1_r;
    end
  end

  // Stage 3: ramp value times 60 for each channel.
  logic [NUM_W-1:0] base60, nr_nxt, ng_nxt, nb_nxt;
  logic [NUM_W-1:0] nr3_r, ng3_r, nb3_r;

  always_comb begin
    base60 = (NUM_W'(m1_2_r) << 6) - (NUM_W'(m1_2_r) << 2);
    nr_nxt = base60 + NUM_W'(d2_r) * NUM_W'(kr2_r);
    ng_nxt = base60 + NUM_W'(d2_r) * NUM_W'(kg2_r);
    nb_nxt = base60 + NUM_W'(d2_r) * NUM_W'(kb2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (rdy3 && v2_r) begin
      nr3_r <= nr_nxt;
      ng3_r <= ng_nxt;
      nb3_r <= nb_nxt;
    end
  end

  // Stage 4: 255/60 is 17/4, so the byte is (17 * num) >> (2F + 2).
  function automatic logic [CHAN_W-1:0] to_byte(input logic [NUM_W-1:0] num);
    logic [PRD_W-1:0]  prd;
    logic [CHAN_W:0]   hi;
    prd = (PRD_W'(num) << 4) + PRD_W'(num);
    hi  = prd[PRD_W-1:SHR];
    return hi[CHAN_W] ? CHAN_MAX : hi[CHAN_W-1:0];
  endfunction

  hsl_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
    if (rdy4 && v3_r) begin
      out_r.red   <= to_byte(nr3_r);
      out_r.green <= to_byte(ng3_r);
      out_r.blue  <= to_byte(nb3_r);
    end
  end

  assign out_data = out_r;

endmodule

>>> sv/hsl_chk.sv
// ----------------------------------------------------------------------------
// hsl_chk
// Port-level checks for the HSL to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsl_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input hsl_pkg::hsl_in_t   in_data,
  input logic               out_valid,
  input logic               out_stall,
  input hsl_pkg::hsl_out_t  out_data
);
  import hsl_pkg::*;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // With an empty output stage the pipeline can always take a word.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // Zero lightness is black; once the output has moved on in every cycle while
  // the word passes through the pipeline, the word is offered at the output.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.lightness == '0) ##1 !out_stall [*3]
    |=> out_valid && out_data.red == '0 && out_data.green == '0 &&
        out_data.blue == '0)
    else $error("black input did not give a black result on time");

endmodule

bind hsl_to_rgb_converter hsl_chk u_hsl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
